>>> rtl/core/m2malu_pkg.sv
package m2malu_pkg;

	// Data memory geometry
	localparam int MEM_DEPTH = 256;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);
	localparam int DATA_W    = 32;
	localparam int CNT_W     = $clog2(DATA_W);

	// Request field widths
	localparam int OP_W     = 4;
	localparam int FADDR_W  = 8;
	// dest, src_a, src_b, imm_value, read_value packed into tdata
	localparam int IN_DATA_W  = 3 * FADDR_W + 2 * DATA_W;
	localparam int OUT_USER_W = 2;

	// Opcodes; the remaining codes do nothing
	localparam logic [OP_W-1:0] OP_ADD = 4'd0;
	localparam logic [OP_W-1:0] OP_SUB = 4'd1;
	localparam logic [OP_W-1:0] OP_MUL = 4'd2;
	localparam logic [OP_W-1:0] OP_DIV = 4'd3;
	localparam logic [OP_W-1:0] OP_RED = 4'd5;
	localparam logic [OP_W-1:0] OP_WRT = 4'd6;
	localparam logic [OP_W-1:0] OP_STR = 4'd7;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_WB
	} state_t;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [FADDR_W-1:0] dest;
		logic [FADDR_W-1:0] src_a;
		logic [FADDR_W-1:0] src_b;
		logic [DATA_W-1:0]  imm;
		logic [DATA_W-1:0]  rv;
	} instr_t;

	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_a_addr;
		logic [ADDR_W-1:0] rd_b_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [DATA_W-1:0] wr_data;
	} mem_req_t;

endpackage

>>> rtl/core/m2malu_mem.sv
module m2malu_mem (
	input  logic                         clk,
	input  logic                         arst_n,
	input  m2malu_pkg::mem_req_t         req,
	output logic [m2malu_pkg::DATA_W-1:0] rd_a_data,
	output logic [m2malu_pkg::DATA_W-1:0] rd_b_data
);
	import m2malu_pkg::*;

	logic [DATA_W-1:0]    mem_q [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] vld_q;
	logic [DATA_W-1:0]    rd_a_q;
	logic [DATA_W-1:0]    rd_b_q;
	logic                 rd_a_vld_q;
	logic                 rd_b_vld_q;

	// Storage array: one write, two registered reads
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_a_q <= mem_q[req.rd_a_addr];
			rd_b_q <= mem_q[req.rd_b_addr];
		end
	end

	// Entry valid bits: an unwritten word reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			rd_a_vld_q <= 1'b0;
			rd_b_vld_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_a_vld_q <= vld_q[req.rd_a_addr];
				rd_b_vld_q <= vld_q[req.rd_b_addr];
			end
		end
	end

	assign rd_a_data = rd_a_vld_q ? rd_a_q : '0;
	assign rd_b_data = rd_b_vld_q ? rd_b_q : '0;

endmodule

>>> rtl/core/m2malu_div.sv
module m2malu_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [m2malu_pkg::DATA_W-1:0] dividend,
	input  logic [m2malu_pkg::DATA_W-1:0] divisor,
	output logic                          done,
	output logic [m2malu_pkg::DATA_W-1:0] quotient
);
	import m2malu_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              neg_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] dvs_q;
	logic [DATA_W:0]   rem_sh;
	logic [DATA_W:0]   diff;
	logic              take;

	// One restoring step per cycle on the magnitudes
	assign rem_sh = {rem_q, quo_q[DATA_W-1]};
	assign diff   = rem_sh - {1'b0, dvs_q};
	assign take   = !diff[DATA_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(DATA_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
			rem_q <= '0;
			quo_q <= dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
			dvs_q <= divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
		end else if (busy_q) begin
			rem_q <= take ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
			quo_q <= {quo_q[DATA_W-2:0], take};
		end
	end

	// Truncate toward zero: fix the sign of the magnitude quotient
	assign done     = done_q;
	assign quotient = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

>>> rtl/core/memory_to_memory_alu_exec_core.sv
// Memory-to-memory ALU executor.
//
// Each request on the slave stream is one three-address instruction run
// against a 256-word data memory of signed 32-bit words. Arithmetic opcodes
// compute dest = mem[a] op mem[b]; store and read put the request's
// immediate or external value into dest; write returns mem[dest]. Every
// request gives exactly one response on the master stream, carrying the
// word (write opcode only, else zero), an output-valid flag and a
// divide-by-zero flag. Unused opcodes give an all-zero response.
//
// Timing: a request is taken only while the core is idle. Add, subtract,
// multiply, store, read, write and no-op requests pass from acceptance
// through execute and write-back to idle, the response being registered as
// write-back ends. A divide with a nonzero divisor also waits in a divide
// state on the radix-2 divider, one quotient bit per cycle over 32 steps.
//
// Reset clears every memory word to zero through per-word valid bits; the
// core leaves reset idle and ready to take a request. When the receiver stalls,
// one finished response waits in the output register while the next request
// is taken and executed; that request holds in write-back until the slot
// frees, so memory is never updated ahead of its response.
module memory_to_memory_alu_exec_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// dest_addr[7:0], src_a_addr[15:8], src_b_addr[23:16],
	// imm_value[55:24], read_value[87:56]
	input  logic [m2malu_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// req_type[3:0]
	input  logic [m2malu_pkg::OP_W-1:0]           s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// out_value[31:0]
	output logic [m2malu_pkg::DATA_W-1:0]         m_axis_tdata,
	// out_valid[0], div_zero_err[1]
	output logic [m2malu_pkg::OUT_USER_W-1:0]     m_axis_tuser
);
	import m2malu_pkg::*;

	state_t            state_q;
	state_t            state_d;
	instr_t            instr_in;
	instr_t            instr_q;
	mem_req_t          mem_req;
	logic [DATA_W-1:0] opa;
	logic [DATA_W-1:0] opb;
	logic [DATA_W-1:0] res_q;
	logic              wr_q;
	logic              wrt_q;
	logic              err_q;
	logic              div_start;
	logic              div_done;
	logic [DATA_W-1:0] div_quo;
	logic              s_accept;
	logic              out_free;
	logic              out_load;
	logic              m_vld_q;
	logic [DATA_W-1:0] m_data_q;
	logic [OUT_USER_W-1:0] m_user_q;

	// Unpack the request fields, lowest bits first
	assign instr_in.op    = s_axis_tuser;
	assign instr_in.dest  = s_axis_tdata[FADDR_W-1:0];
	assign instr_in.src_a = s_axis_tdata[2*FADDR_W-1:FADDR_W];
	assign instr_in.src_b = s_axis_tdata[3*FADDR_W-1:2*FADDR_W];
	assign instr_in.imm   = s_axis_tdata[3*FADDR_W+DATA_W-1:3*FADDR_W];
	assign instr_in.rv    = s_axis_tdata[IN_DATA_W-1:3*FADDR_W+DATA_W];

	assign s_accept = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_vld_q || m_axis_tready;

	m2malu_mem u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (mem_req),
		.rd_a_data (opa),
		.rd_b_data (opb)
	);

	m2malu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (opa),
		.divisor  (opb),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (instr_q.op == OP_DIV && opb != '0) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_WB;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_WB;
				end
			end
			ST_WB: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs: read operands on acceptance, write back when the
	// response slot frees
	always_comb begin
		s_axis_tready     = (state_q == ST_IDLE);
		div_start         = (state_q == ST_EXEC) && (instr_q.op == OP_DIV) && (opb != '0);
		out_load          = (state_q == ST_WB) && out_free;
		mem_req.rd_en     = s_accept;
		mem_req.rd_a_addr = (instr_in.op == OP_WRT) ? instr_in.dest[ADDR_W-1:0]
		                                            : instr_in.src_a[ADDR_W-1:0];
		mem_req.rd_b_addr = instr_in.src_b[ADDR_W-1:0];
		mem_req.wr_en     = out_load && wr_q;
		mem_req.wr_addr   = instr_q.dest[ADDR_W-1:0];
		mem_req.wr_data   = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				m_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_vld_q <= 1'b0;
			end
		end
	end

	// Execute datapath
	always_ff @(posedge clk) begin
		if (s_accept) begin
			instr_q <= instr_in;
		end
		if (state_q == ST_EXEC) begin
			case (instr_q.op)
				OP_ADD: begin
					res_q <= opa + opb;
					wr_q  <= 1'b1;
					wrt_q <= 1'b0;
					err_q <= 1'b0;
				end
				OP_SUB: begin
					res_q <= opa - opb;
					wr_q  <= 1'b1;
					wrt_q <= 1'b0;
					err_q <= 1'b0;
				end
				OP_MUL: begin
					res_q <= opa * opb;
					wr_q  <= 1'b1;
					wrt_q <= 1'b0;
					err_q <= 1'b0;
				end
				OP_DIV: begin
					// zero divisor: flag, leave memory alone
					res_q <= '0;
					wr_q  <= (opb != '0);
					wrt_q <= 1'b0;
					err_q <= (opb == '0);
				end
				OP_RED: begin
					res_q <= instr_q.rv;
					wr_q  <= 1'b1;
					wrt_q <= 1'b0;
					err_q <= 1'b0;
				end
				OP_WRT: begin
					res_q <= opa;
					wr_q  <= 1'b0;
					wrt_q <= 1'b1;
					err_q <= 1'b0;
				end
				OP_STR: begin
					res_q <= instr_q.imm;
					wr_q  <= 1'b1;
					wrt_q <= 1'b0;
					err_q <= 1'b0;
				end
				default: begin
					res_q <= '0;
					wr_q  <= 1'b0;
					wrt_q <= 1'b0;
					err_q <= 1'b0;
				end
			endcase
		end else if (state_q == ST_DIV && div_done) begin
			res_q <= div_quo;
		end
		if (out_load) begin
			m_data_q <= wrt_q ? res_q : '0;
			m_user_q <= {err_q, wrt_q};
		end
	end

	assign m_axis_tvalid = m_vld_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> state_q == ST_EXEC)
		else $error("accepted request did not enter execute");

	a_wr_in_wb: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_en |-> state_q == ST_WB && !err_q)
		else $error("memory write outside write-back or on divide error");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> opb != '0)
		else $error("divider started with zero divisor");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !(m_axis_tvalid && !m_axis_tready))
		else $error("response register overwritten while stalled");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1])
		else $error("write response flagged with divide error");

endmodule

>>> test/memory_to_memory_alu_exec_core_tb.sv
module memory_to_memory_alu_exec_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import m2malu_pkg::*;

	// Opcodes that the core treats as no-ops
	localparam logic [OP_W-1:0] OP_EXP = 4'd4;
	localparam logic [OP_W-1:0] OP_JMP = 4'd8;
	localparam logic [OP_W-1:0] OP_CJP = 4'd9;
	localparam int OP_LAST = 2**OP_W - 1;

	// Divide is the slowest path; allow some margin on top
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 400_000;
	localparam int REPORT_LIMIT  = 10;

	typedef struct {
		logic [OP_W-1:0]    op;
		logic [FADDR_W-1:0] dest;
		logic [FADDR_W-1:0] src_a;
		logic [FADDR_W-1:0] src_b;
		logic [DATA_W-1:0]  imm;
		logic [DATA_W-1:0]  rv;
	} alu_request_t;

	typedef struct {
		logic              out_valid;
		logic              div_zero_err;
		logic [DATA_W-1:0] out_value;
	} alu_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic [OP_W-1:0]       s_axis_tuser  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [DATA_W-1:0]     m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;

	// Our own copy of the data memory, advanced as each request is accepted
	logic [DATA_W-1:0] shadow_mem [MEM_DEPTH];
	alu_result_t       awaited_results [$];

	int  fail_count  = 0;
	int  cycle_count = 0;
	int  rx_left     = 0;
	// Turn off idling on either side for back-to-back stretches
	bit  tx_no_gaps  = 1'b0;
	bit  rx_no_stall = 1'b0;

	memory_to_memory_alu_exec_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #4 clk = ~clk;

	// Hard stop in case the core hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, awaited_results.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Bias data words toward the edges of the signed range
	function automatic logic [DATA_W-1:0] pick_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 32'h8000_0000;
		else if (r < 16)
			return 32'h7FFF_FFFF;
		else if (r < 22)
			return '1;
		else if (r < 26)
			return '0;
		else if (r < 30)
			return 32'd1;
		return $urandom();
	endfunction

	// Any word address; used where the field does not matter
	function automatic logic [FADDR_W-1:0] rand_addr();
		return FADDR_W'($urandom());
	endfunction

	function automatic alu_request_t make_req(logic [OP_W-1:0] op, logic [FADDR_W-1:0] dest,
			logic [FADDR_W-1:0] src_a, logic [FADDR_W-1:0] src_b,
			logic [DATA_W-1:0] imm, logic [DATA_W-1:0] rv);
		alu_request_t r;
		r.op    = op;
		r.dest  = dest;
		r.src_a = src_a;
		r.src_b = src_b;
		r.imm   = imm;
		r.rv    = rv;
		return r;
	endfunction

	// Truncating signed divide on bit patterns; wraps min / -1 back to min
	function automatic logic [DATA_W-1:0] signed_quotient(logic [DATA_W-1:0] a,
			logic [DATA_W-1:0] b);
		logic [DATA_W-1:0] mag_a, mag_b, q;
		mag_a = a[DATA_W-1] ? -a : a;
		mag_b = b[DATA_W-1] ? -b : b;
		q     = mag_a / mag_b;
		return (a[DATA_W-1] ^ b[DATA_W-1]) ? -q : q;
	endfunction

	// Apply one instruction to the shadow memory and return its response
	function automatic alu_result_t execute_on_shadow(alu_request_t r);
		alu_result_t       res;
		logic [DATA_W-1:0] a, b;
		a   = shadow_mem[r.src_a];
		b   = shadow_mem[r.src_b];
		res = '{out_valid: 1'b0, div_zero_err: 1'b0, out_value: '0};
		case (r.op)
			OP_ADD: shadow_mem[r.dest] = a + b;
			OP_SUB: shadow_mem[r.dest] = a - b;
			OP_MUL: shadow_mem[r.dest] = a * b;
			OP_DIV: begin
				// leave memory alone on a zero divisor
				if (b == '0)
					res.div_zero_err = 1'b1;
				else
					shadow_mem[r.dest] = signed_quotient(a, b);
			end
			OP_RED: shadow_mem[r.dest] = r.rv;
			OP_STR: shadow_mem[r.dest] = r.imm;
			OP_WRT: begin
				res.out_valid = 1'b1;
				res.out_value = shadow_mem[r.dest];
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic alu_request_t random_request();
		alu_request_t r;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 12)
			r.op = OP_STR;
		else if (pick < 22)
			r.op = OP_RED;
		else if (pick < 32)
			r.op = OP_ADD;
		else if (pick < 42)
			r.op = OP_SUB;
		else if (pick < 52)
			r.op = OP_MUL;
		else if (pick < 67)
			r.op = OP_DIV;
		else if (pick < 90)
			r.op = OP_WRT;
		else
			r.op = OP_W'($urandom());
		// keep most traffic on a few words so results feed later requests
		if ($urandom_range(0, 4) != 0) begin
			r.dest  = FADDR_W'($urandom_range(0, 15));
			r.src_a = FADDR_W'($urandom_range(0, 15));
			r.src_b = FADDR_W'($urandom_range(0, 15));
		end else begin
			r.dest  = FADDR_W'($urandom_range(0, MEM_DEPTH - 1));
			r.src_a = FADDR_W'($urandom_range(0, MEM_DEPTH - 1));
			r.src_b = FADDR_W'($urandom_range(0, MEM_DEPTH - 1));
		end
		r.imm = pick_word();
		r.rv  = pick_word();
		return r;
	endfunction

	task automatic log_failure(string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("%0d: %s", cycle_count, msg);
	endtask

	// Send one request; returns just after the edge that accepts it.
	// Valid is lowered only on a gap and raised on a later edge.
	task automatic send_request(alu_request_t r);
		int gap;
		gap = tx_no_gaps ? 0 : pick_gap();
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {r.rv, r.imm, r.src_b, r.src_a, r.dest};
		s_axis_tuser  <= r.op;
		do
			@(posedge clk);
		while (!s_axis_tready);
		awaited_results.push_back(execute_on_shadow(r));
	endtask

	// Hold the sender until every outstanding response is back
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Receiver: alternate random ready bursts and stalls
	always @(posedge clk) begin
		int stall;
		if (rx_no_stall) begin
			m_axis_tready <= 1'b1;
			rx_left = 0;
		end else if (rx_left != 0) begin
			rx_left--;
		end else begin
			stall = pick_gap();
			if (stall == 0) begin
				m_axis_tready <= 1'b1;
				rx_left = $urandom_range(0, 10);
			end else begin
				m_axis_tready <= 1'b0;
				rx_left = stall - 1;
			end
		end
	end

	// Compare each accepted response with the oldest prediction
	always @(posedge clk) begin
		alu_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (awaited_results.size() == 0) begin
				log_failure($sformatf("unexpected response: value %h user %b",
					m_axis_tdata, m_axis_tuser));
			end else begin
				want = awaited_results.pop_front();
				if (m_axis_tdata !== want.out_value)
					log_failure($sformatf("out_value: expected %h, got %h",
						want.out_value, m_axis_tdata));
				if (m_axis_tuser[0] !== want.out_valid)
					log_failure($sformatf("out_valid: expected %b, got %b",
						want.out_valid, m_axis_tuser[0]));
				if (m_axis_tuser[1] !== want.div_zero_err)
					log_failure($sformatf("div_zero_err: expected %b, got %b",
						want.div_zero_err, m_axis_tuser[1]));
			end
		end
	end

	// Edge values through every arithmetic path, then read the words back
	task automatic test_directed_extremes();
		logic [FADDR_W-1:0] read_back [7] = '{8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd10, 8'd12};
		send_request(make_req(OP_STR, 8'd0,   rand_addr(), rand_addr(), 32'h7FFF_FFFF, $urandom()));
		send_request(make_req(OP_STR, 8'd255, rand_addr(), rand_addr(), 32'h8000_0000, $urandom()));
		send_request(make_req(OP_RED, 8'd1,   rand_addr(), rand_addr(), $urandom(), 32'hFFFF_FFFF));
		// max + min, min - max, max * max
		send_request(make_req(OP_ADD, 8'd2, 8'd0,   8'd255, $urandom(), $urandom()));
		send_request(make_req(OP_SUB, 8'd3, 8'd255, 8'd0,   $urandom(), $urandom()));
		send_request(make_req(OP_MUL, 8'd4, 8'd0,   8'd0,   $urandom(), $urandom()));
		// most negative over minus one wraps
		send_request(make_req(OP_DIV, 8'd5, 8'd255, 8'd1,   $urandom(), $urandom()));
		// zero divisor: word 10 still holds its reset value
		send_request(make_req(OP_DIV, 8'd6, 8'd0,   8'd10,  $urandom(), $urandom()));
		send_request(make_req(OP_STR, 8'd8, rand_addr(), rand_addr(), 32'hFFFF_FFF9, $urandom()));
		send_request(make_req(OP_STR, 8'd9, rand_addr(), rand_addr(), 32'd2, $urandom()));
		// -7 / 2 truncates toward zero
		send_request(make_req(OP_DIV, 8'd10, 8'd8,   8'd9, $urandom(), $urandom()));
		send_request(make_req(OP_SUB, 8'd12, 8'd255, 8'd1, $urandom(), $urandom()));
		foreach (read_back[i])
			send_request(make_req(OP_WRT, read_back[i],
				rand_addr(), rand_addr(), $urandom(), $urandom()));
	endtask

	// Unused opcodes must leave memory alone and answer with all zeros
	task automatic test_noop_opcodes();
		send_request(make_req(OP_EXP, 8'd0, 8'd0, 8'd255, $urandom(), $urandom()));
		send_request(make_req(OP_JMP, 8'd0, 8'd1, 8'd0,   $urandom(), $urandom()));
		send_request(make_req(OP_CJP, 8'd0, 8'd0, 8'd1,   $urandom(), $urandom()));
		for (int c = OP_CJP + 1; c <= OP_LAST; c++)
			send_request(make_req(OP_W'(c), 8'd0, rand_addr(), rand_addr(),
				$urandom(), $urandom()));
		send_request(make_req(OP_WRT, 8'd0, rand_addr(), rand_addr(), $urandom(), $urandom()));
	endtask

	task automatic test_random_with_idling(int count);
		repeat (count) send_request(random_request());
	endtask

	// Full-rate traffic: no gaps from the sender, no stalls from the receiver
	task automatic test_random_back_to_back(int count);
		tx_no_gaps  = 1'b1;
		rx_no_stall = 1'b1;
		repeat (count) send_request(random_request());
		tx_no_gaps  = 1'b0;
		rx_no_stall = 1'b0;
	endtask

	initial begin
		int waited;
		foreach (shadow_mem[i])
			shadow_mem[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_extremes();
		test_noop_opcodes();
		test_random_with_idling(200);
		test_random_back_to_back(100);
		// let the pipeline empty completely before resuming
		drain_results();
		test_random_with_idling(150);

		// wait out the last responses, bounded, then a settle window
		s_axis_tvalid <= 1'b0;
		waited = 0;
		while (awaited_results.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (awaited_results.size() != 0)
			log_failure($sformatf("%0d responses never arrived", awaited_results.size()));

		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/m2malu_pkg.sv
rtl/core/m2malu_mem.sv
rtl/core/m2malu_div.sv
rtl/core/memory_to_memory_alu_exec_core.sv
test/memory_to_memory_alu_exec_core_tb.sv
